@@ sv/pdo_value_packer_assert.svh @@
// assertion macros used by the checker file
`ifndef PDO_VALUE_PACKER_ASSERT_SVH
`define PDO_VALUE_PACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PVP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PVP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pvp_pkg.sv @@
// types, constants and register codes of the pdo value packer
package pvp_pkg;

    localparam int VALUE_W    = 64;
    localparam int BITS_W     = 8;
    localparam int IN_DATA_W  = 72;
    localparam int FRAME_W    = 64;
    localparam int FBYTES_W   = 4;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int CNT_W      = 7;
    localparam int OFF_W      = 7;
    localparam int CAP_W      = 4;
    localparam int END_W      = 9;

    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_FRAME_BYTES = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;
    localparam logic [CNT_W-1:0] CNT_SAT   = 7'h7f;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTRY_COUNT    = 2'd0,
        REG_FRAME_CAPACITY = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [CNT_W-1:0] entry_count;
        logic [CAP_W-1:0] frame_capacity;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [BITS_W-1:0]  entry_bits;
        logic               last_value;
    } item_t;

endpackage

@@ sv/pvp_cfg_regs.sv @@
// configuration registers: entry count and frame capacity
module pvp_cfg_regs
    import pvp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ENTRY_COUNT:    cfg_next.entry_count    = cfg_data[CNT_W-1:0];
                REG_FRAME_CAPACITY: cfg_next.frame_capacity = cfg_data[CAP_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.entry_count    <= '0;
            cfg_reg.frame_capacity <= CAP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/pvp_in_stage.sv @@
// input register holding one value beat until the packer takes it
module pvp_in_stage
    import pvp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 item_valid,
    output item_t                item,
    input  logic                 item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign s_tready   = !valid_reg || item_take;
    assign load       = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (item_take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.value      <= s_tdata[VALUE_W-1:0];
            item_reg.entry_bits <= s_tdata[VALUE_W+BITS_W-1:VALUE_W];
            item_reg.last_value <= s_tlast;
        end
    end

endmodule

@@ sv/pvp_pack_core.sv @@
// frame accumulator, bit offset and counters, with the result register
module pvp_pack_core
    import pvp_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int FRAME_BYTES = DEF_FRAME_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  item_valid,
    input  item_t                 item,
    output logic                  item_take,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    localparam logic [CAP_W-1:0] FB_CAP     = CAP_W'(FRAME_BYTES);
    localparam logic [END_W-1:0] FRAME_BITS = END_W'(FRAME_BYTES * 8);
    localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_ENTRIES);

    logic [OFF_W-1:0]    off_reg,   off_next;
    logic [FRAME_W-1:0]  acc_reg,   acc_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic                err_reg,   err_next;
    logic                ovalid_reg, ovalid_next;
    logic [FRAME_W-1:0]  odata_reg, odata_next;
    logic [FBYTES_W-1:0] obytes_reg, obytes_next;
    logic                ostat_reg, ostat_next;

    logic [CAP_W-1:0]    cap_bytes;
    logic [END_W-1:0]    cap_bits;
    logic [END_W-1:0]    end_bits;
    logic [FRAME_W-1:0]  len_mask;
    logic [FRAME_W-1:0]  insert;
    logic [OFF_W-1:0]    off_step;
    logic [FRAME_W-1:0]  acc_step;
    logic [CNT_W-1:0]    cnt_step;
    logic                err_step;
    logic                bad;
    logic [OFF_W-1:0]    round_up;

    // a last beat needs a free result slot, other beats never wait
    assign item_take = item_valid && (!item.last_value || !ovalid_reg || m_tready);

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-FRAME_W-FBYTES_W){1'b0}}, obytes_reg, odata_reg};
    assign m_tuser  = ostat_reg;

    always_comb
    begin
        cap_bytes = (cfg.frame_capacity > FB_CAP) ? FB_CAP : cfg.frame_capacity;
        cap_bits  = END_W'({cap_bytes, 3'b000});
        end_bits  = END_W'(off_reg) + END_W'(item.entry_bits);
        len_mask  = (item.entry_bits >= BITS_W'(FRAME_W)) ? '1
                  : ((FRAME_W'(1) << item.entry_bits[5:0]) - FRAME_W'(1));
        insert    = (item.value & len_mask) << off_reg[5:0];

        cnt_step = (cnt_reg == CNT_SAT) ? cnt_reg : cnt_reg + CNT_W'(1);
        err_step = err_reg;
        off_step = off_reg;
        acc_step = acc_reg;
        if (!err_reg)
        begin
            if (end_bits > FRAME_BITS)
                err_step = 1'b1;
            else
            begin
                // beyond capacity the bits are dropped but the offset still moves
                if (item.entry_bits != '0 && end_bits <= cap_bits)
                    acc_step = acc_reg | insert;
                off_step = end_bits[OFF_W-1:0];
            end
        end

        bad      = err_step || (cfg.entry_count > MAX_CNT) || (cnt_step != cfg.entry_count);
        // offset is at most 64, so the rounded sum stays below 128
        round_up = off_step + OFF_W'(7);

        off_next    = off_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        odata_next  = odata_reg;
        obytes_next = obytes_reg;
        ostat_next  = ostat_reg;
        ovalid_next = ovalid_reg && !m_tready;

        if (item_take)
        begin
            if (item.last_value)
            begin
                off_next    = '0;
                acc_next    = '0;
                cnt_next    = '0;
                err_next    = 1'b0;
                ovalid_next = 1'b1;
                ostat_next  = bad;
                odata_next  = bad ? '0 : acc_step;
                obytes_next = bad ? '0 : round_up[OFF_W-1:3];
            end
            else
            begin
                off_next = off_step;
                acc_next = acc_step;
                cnt_next = cnt_step;
                err_next = err_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg    <= '0;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            err_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            off_reg    <= off_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            err_reg    <= err_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg  <= odata_next;
        obytes_reg <= obytes_next;
        ostat_reg  <= ostat_next;
    end

endmodule

@@ sv/pdo_value_packer.sv @@
// a value beat enters the input register, the frame beat then leaves the result register
// throughput: one value beat per cycle from the combinational offset add and insert, but
// a last beat waits only while the previous frame beat is still unread
// reset (rst_n low, asynchronous) empties both registers and the frame being built
// reset loads entry_count 0 and frame_capacity 8
module pdo_value_packer
    import pvp_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int FRAME_BYTES = DEF_FRAME_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // value[63:0], entry_bits[71:64]
    input  logic                  s_tlast,   // last_value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // frame_data[63:0], frame_bytes[67:64], zero pad
    output logic                  m_tuser,   // status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  item_take;

    pvp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pvp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    pvp_pack_core #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

@@ sv/pvp_checker.sv @@
// port-level checks of the pdo value packer, bound to the top level
`include "pdo_value_packer_assert.svh"

module pvp_checker
    import pvp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    `PVP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "frame beat changed while stalled")

    `PVP_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser, m_tdata == '0, "error frame carries data")

    `PVP_ASSERT_NOW(a_bytes_max, m_tvalid && !m_tuser, m_tdata[FRAME_W+FBYTES_W-1:FRAME_W] <= FBYTES_W'(DEF_FRAME_BYTES), "byte count above frame size")

    `PVP_ASSERT_NOW(a_ready_flow, m_tready, s_tready, "input stalled while output side is ready")

endmodule

bind pdo_value_packer pvp_checker u_pvp_checker (.*);
